/* rtl/core/rasn_pkg.sv */
// Package for the rational add/sub/normalize block: opcodes, widths, constants.
// Used by rasn_divu and rational_add_sub_normalize.
package rasn_pkg;
   localparam int OperandWidthDefault = 32;
   localparam int MagW = 64;

   localparam logic [1:0] OP_NORM = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_SUB  = 2'd2;
   localparam logic [1:0] OP_EQ   = 2'd3;

   typedef logic [MagW-1:0] mag_type;

   localparam mag_type MAX63 = {1'b0, {(MagW-1){1'b1}}};
endpackage

/* rtl/core/rasn_divu.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Uses rasn_pkg for the magnitude type.
module rasn_divu
   import rasn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  mag_type dividend,
   input  mag_type divisor,
   output logic    done,
   output mag_type quot,
   output mag_type rem
);
   mag_type q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [MagW:0] sh;
   logic [MagW:0] diff;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh = {r_ff, q_ff[MagW-1]};
      diff = sh - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[MagW]) begin
            r_in = diff[MagW-1:0];
            q_in = {q_ff[MagW-2:0], 1'b1};
         end else begin
            r_in = sh[MagW-1:0];
            q_in = {q_ff[MagW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(MagW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem = r_ff;
endmodule

/* rtl/core/rational_add_sub_normalize.sv */
// Channel | ports        | role
// req     | req_valid/rd | opcode and two fractions in
// rsp     | rsp_valid/rd | reduced fraction and flags out
// One request at a time; a sequencer reuses one 64-step divider for every
// Euclid remainder and both final divisions. Up to three reductions per request
// (a, b, then the sum): at most ~46 steps on 32-bit magnitudes and ~92 on the
// 64-bit sum.
// Reset clears the sequencer and the response valid.
// A waiting response does not block the next request being taken.
module rational_add_sub_normalize
   import rasn_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [63:0] rsp_res_num,
   output logic [62:0] rsp_res_den,
   output logic        rsp_is_equal,
   output logic        rsp_den_zero,
   output logic        rsp_overflow
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RED   = 4'd1; // start reduction of cur
   localparam logic [3:0] S_GCD   = 4'd2; // start remainder division, or end gcd
   localparam logic [3:0] S_DIVN  = 4'd3;
   localparam logic [3:0] S_DIVD  = 4'd4;
   localparam logic [3:0] S_NEXT  = 4'd5;
   localparam logic [3:0] S_MUL1  = 4'd6;
   localparam logic [3:0] S_MUL2  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;
   localparam logic [3:0] S_WAIT  = 4'd9;
   localparam logic [3:0] S_GCDW  = 4'd10;

   logic [3:0] st_ff, st_in;
   logic [1:0] phase_ff, phase_in; // 0 reduce a, 1 reduce b, 2 reduce sum
   logic [1:0] op_ff, op_in;
   logic [31:0] bn_ff, bn_in, bd_ff, bd_in;
   // current reduction operands
   logic    cneg_ff, cneg_in, dneg_ff, dneg_in;
   mag_type cn_ff, cn_in, cd_ff, cd_in, x_ff, x_in, y_ff, y_in, g_ff, g_in;
   mag_type rn_ff, rn_in, rd_ff, rd_in;
   // saved normal forms
   logic    an_ff, an_in, bneg_ff, bneg_in;
   mag_type anum_ff, anum_in, aden_ff, aden_in, bnum_ff, bnum_in, bden_ff, bden_in;
   mag_type p_ff, p_in;
   logic    rv_ff, rv_in;
   logic signed [63:0] on_ff, on_in;
   logic [62:0] od_ff, od_in;
   logic oe_ff, oe_in, oz_ff, oz_in, oo_ff, oo_in;

   logic    dstart, ddone;
   mag_type ddvd, ddvs, dq, dr;

   logic [31:0] mult_a, mult_b;
   mag_type     prod;
   logic        rneg;
   mag_type     qv, smag;
   logic        qs, sneg;

   rasn_divu u_div (
      .clock, .reset, .start(dstart), .dividend(ddvd), .divisor(ddvs),
      .done(ddone), .quot(dq), .rem(dr)
   );

   function automatic logic sgn(input logic [31:0] v);
      return v[OPERAND_WIDTH-1];
   endfunction
   function automatic mag_type mag(input logic [31:0] v);
      logic [31:0] m;
      logic [31:0] mask;
      mask = 32'((64'd1 << OPERAND_WIDTH) - 64'd1);
      m = v & mask;
      if (m[OPERAND_WIDTH-1]) m = (~m + 32'd1) & mask;
      return MagW'(m);
   endfunction

   assign prod = MagW'(mult_a) * MagW'(mult_b);
   assign rneg = (rd_ff != '0) ? (cneg_ff != dneg_ff) : cneg_ff;

   always_comb begin
      st_in = st_ff; phase_in = phase_ff; op_in = op_ff;
      bn_in = bn_ff; bd_in = bd_ff;
      cneg_in = cneg_ff; dneg_in = dneg_ff; cn_in = cn_ff; cd_in = cd_ff;
      x_in = x_ff; y_in = y_ff; g_in = g_ff; rn_in = rn_ff; rd_in = rd_ff;
      an_in = an_ff; bneg_in = bneg_ff; anum_in = anum_ff; aden_in = aden_ff;
      bnum_in = bnum_ff; bden_in = bden_ff; p_in = p_ff;
      rv_in = rv_ff; on_in = on_ff; od_in = od_ff;
      oe_in = oe_ff; oz_in = oz_ff; oo_in = oo_ff;
      dstart = 1'b0; ddvd = x_ff; ddvs = y_ff;
      mult_a = anum_ff[31:0]; mult_b = bden_ff[31:0];
      qv = '0; qs = 1'b0; sneg = 1'b0; smag = '0;
      if (rsp_valid && rsp_ready) rv_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode; bn_in = req_b_num; bd_in = req_b_den;
               cneg_in = sgn(req_a_num); cn_in = mag(req_a_num);
               dneg_in = sgn(req_a_den); cd_in = mag(req_a_den);
               phase_in = 2'd0;
               st_in = S_RED;
            end
         end
         S_RED: begin
            if (cn_ff == '0) begin
               rn_in = '0; rd_in = 64'd1; cneg_in = 1'b0; dneg_in = 1'b0;
               st_in = S_NEXT;
            end else begin
               x_in = cn_ff; y_in = cd_ff;
               st_in = S_GCD;
            end
         end
         S_GCD: begin
            if (x_ff == '0 || y_ff == '0) begin
               g_in = x_ff | y_ff;
               ddvd = cn_ff; ddvs = x_ff | y_ff; dstart = 1'b1;
               st_in = S_DIVN;
            end else begin
               if (x_ff > y_ff) begin ddvd = x_ff; ddvs = y_ff; end
               else begin ddvd = y_ff; ddvs = x_ff; end
               dstart = 1'b1;
               st_in = S_GCDW;
            end
         end
         S_GCDW: begin
            if (ddone) begin
               if (x_ff > y_ff) x_in = dr; else y_in = dr;
               st_in = S_GCD;
            end
         end
         S_DIVN: begin
            if (ddone) begin
               rn_in = dq;
               ddvd = cd_ff; ddvs = g_ff; dstart = 1'b1;
               st_in = S_DIVD;
            end
         end
         S_DIVD: begin
            if (ddone) begin
               rd_in = dq;
               st_in = S_NEXT;
            end
         end
         S_NEXT: begin
            case (phase_ff)
               2'd0: begin
                  an_in = rneg; anum_in = rn_ff; aden_in = rd_ff;
                  if (op_ff == OP_NORM) st_in = S_OUT;
                  else begin
                     cneg_in = sgn(bn_ff); cn_in = mag(bn_ff);
                     dneg_in = sgn(bd_ff); cd_in = mag(bd_ff);
                     phase_in = 2'd1; st_in = S_RED;
                  end
               end
               2'd1: begin
                  bneg_in = rneg; bnum_in = rn_ff; bden_in = rd_ff;
                  if (op_ff == OP_EQ) st_in = S_OUT;
                  else st_in = S_MUL1;
               end
               default: st_in = S_OUT;
            endcase
         end
         S_MUL1: begin
            p_in = prod; // a.num * b.den
            st_in = S_MUL2;
         end
         S_MUL2: begin
            mult_a = bnum_ff[31:0]; mult_b = aden_ff[31:0];
            qv = prod;
            qs = (op_ff == OP_SUB) ? !bneg_ff : bneg_ff;
            if (an_ff == qs) begin smag = p_ff + qv; sneg = an_ff; end
            else if (p_ff >= qv) begin smag = p_ff - qv; sneg = an_ff; end
            else begin smag = qv - p_ff; sneg = qs; end
            cneg_in = sneg; cn_in = smag; dneg_in = 1'b0;
            x_in = '0; // den product computed next
            st_in = S_WAIT;
         end
         S_WAIT: begin
            mult_a = aden_ff[31:0]; mult_b = bden_ff[31:0];
            cd_in = prod;
            phase_in = 2'd2; st_in = S_RED;
         end
         S_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               oe_in = 1'b0; oz_in = 1'b0; oo_in = 1'b0;
               if (op_ff == OP_EQ) begin
                  on_in = '0; od_in = 63'd1;
                  oe_in = (an_ff == rneg) && (anum_ff == rn_ff) && (aden_ff == rd_ff);
               end else begin
                  if (rneg) begin
                     if (rn_ff > MAX63 + 64'd1) begin oo_in = 1'b1; on_in = 64'(MAX63 + 64'd1); end
                     else on_in = 64'('0 - rn_ff);
                  end else if (rn_ff > MAX63) begin oo_in = 1'b1; on_in = 64'(MAX63); end
                  else on_in = 64'(rn_ff);
                  if (rd_ff > MAX63) begin oo_in = 1'b1; od_in = MAX63[62:0]; end
                  else od_in = rd_ff[62:0];
                  oz_in = (rd_ff == '0);
               end
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rv_ff <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         phase_ff <= phase_in;
      end
      op_ff <= op_in; bn_ff <= bn_in; bd_ff <= bd_in;
      cneg_ff <= cneg_in; dneg_ff <= dneg_in; cn_ff <= cn_in; cd_ff <= cd_in;
      x_ff <= x_in; y_ff <= y_in; g_ff <= g_in; rn_ff <= rn_in; rd_ff <= rd_in;
      an_ff <= an_in; bneg_ff <= bneg_in; anum_ff <= anum_in; aden_ff <= aden_in;
      bnum_ff <= bnum_in; bden_ff <= bden_in; p_ff <= p_in;
      on_ff <= on_in; od_ff <= od_in; oe_ff <= oe_in; oz_ff <= oz_in; oo_ff <= oo_in;
   end

   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_res_num = on_ff;
   assign rsp_res_den = od_ff;
   assign rsp_is_equal = oe_ff;
   assign rsp_den_zero = oz_ff;
   assign rsp_overflow = oo_ff;
endmodule

/* bench/rational_add_sub_normalize_tb.sv */
// Testbench for rational_add_sub_normalize: directed table plus random requests,
// each response checked against a typed-in expectation or a behavioral fraction predictor.
// Depends on rasn_pkg and the rational_add_sub_normalize RTL.
`timescale 1ns / 100ps

module rational_add_sub_normalize_tb;
   import rasn_pkg::*;

   typedef struct {
      logic signed [63:0] num;
      logic [62:0]        den;
      logic               eq;
      logic               dz;
      logic               ovf;
   } frac_rsp_type;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] an, ad, bn, bd;
      logic               known;   // expected result typed in
      frac_rsp_type       exp;
   } req_row_type;

   typedef struct {
      logic        neg;
      logic [63:0] num;
      logic [63:0] den;
   } frac_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_opcode;
   logic signed [31:0] req_a_num, req_a_den, req_b_num, req_b_den;
   logic rsp_valid, rsp_ready;
   logic signed [63:0] rsp_res_num;
   logic [62:0] rsp_res_den;
   logic rsp_is_equal, rsp_den_zero, rsp_overflow;

   frac_rsp_type pending_fracs[$];
   int           err_cnt;
   bit           calm;        // no idling near the end
   bit           hold_rsp;    // long receiver hold-off
   req_row_type  dir_tab[$];

   rational_add_sub_normalize dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1000ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      while (x > 0 && y > 0) begin
         if (x > y) x = x % y;
         else y = y % x;
      end
      return x + y;
   endfunction

   function automatic frac_type reduce_frac(logic nneg, logic [63:0] nm, logic dneg,
                                            logic [63:0] dm);
      frac_type r;
      logic [63:0] g;
      if (nm == 0) begin
         r.neg = 0; r.num = 0; r.den = 1;
         return r;
      end
      g = gcd64(nm, dm);
      r.num = nm / g;
      r.den = dm / g;
      r.neg = (r.den != 0) ? (nneg != dneg) : nneg;
      return r;
   endfunction

   function automatic frac_type frac_of(logic signed [31:0] n, logic signed [31:0] d);
      logic [63:0] nm, dm;
      nm = n[31] ? 64'(-{1'b0, n}) & 64'hFFFF_FFFF : 64'(n) & 64'hFFFF_FFFF;
      dm = d[31] ? 64'(-{1'b0, d}) & 64'hFFFF_FFFF : 64'(d) & 64'hFFFF_FFFF;
      return reduce_frac(n[31], nm, d[31], dm);
   endfunction

   function automatic frac_rsp_type predict_frac(req_row_type rq);
      frac_type a, b, r;
      logic [63:0] p, q, smag;
      logic ps, qs, sneg;
      frac_rsp_type o;
      a = frac_of(rq.an, rq.ad);
      b = frac_of(rq.bn, rq.bd);
      o = '{num: 0, den: 1, eq: 0, dz: 0, ovf: 0};
      if (rq.op == OP_EQ) begin
         o.eq = (a.neg == b.neg && a.num == b.num && a.den == b.den);
         return o;
      end
      if (rq.op == OP_NORM) r = a;
      else begin
         p = a.num * b.den;
         q = b.num * a.den;
         ps = a.neg;
         qs = (rq.op == OP_SUB) ? !b.neg : b.neg;
         if (ps == qs) begin smag = p + q; sneg = ps; end
         else if (p >= q) begin smag = p - q; sneg = ps; end
         else begin smag = q - p; sneg = qs; end
         r = reduce_frac(sneg, smag, 0, a.den * b.den);
      end
      if (r.neg) begin
         if (r.num > MAX63 + 1) begin o.ovf = 1; o.num = MAX63 + 1; end
         else o.num = 64'd0 - r.num;
      end else if (r.num > MAX63) begin
         o.ovf = 1; o.num = MAX63;
      end else o.num = r.num;
      if (r.den > MAX63) begin o.ovf = 1; o.den = MAX63[62:0]; end
      else o.den = r.den[62:0];
      o.dz = (r.den == 0);
      return o;
   endfunction

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, 12)) - 6;
         1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 2000)) - 1000;
         3: return 32'($urandom_range(0, 1)) * 0;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_row(logic [1:0] op, logic signed [31:0] an, ad, bn, bd,
                          logic known = 0, frac_rsp_type e = '{0, 1, 0, 0, 0});
      req_row_type rw;
      rw.op = op; rw.an = an; rw.ad = ad; rw.bn = bn; rw.bd = bd;
      rw.known = known; rw.exp = e;
      dir_tab.push_back(rw);
   endtask

   // valid drops only for an idle gap, so each edge sees one assignment
   task automatic send_req(req_row_type rw);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1;
      req_opcode <= rw.op;
      req_a_num  <= rw.an; req_a_den <= rw.ad;
      req_b_num  <= rw.bn; req_b_den <= rw.bd;
      pending_fracs.push_back(rw.known ? rw.exp : predict_frac(rw));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // response side: random stalls, one long hold-off
   initial begin
      int n;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp_ready <= 0;
         else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 5);
            repeat (n - 1) @(posedge clock);
         end else rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      frac_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fracs.size() == 0) begin
            $display("%0t: response with nothing expected", $time);
            err_cnt++;
         end else begin
            e = pending_fracs.pop_front();
            if (rsp_res_num !== e.num || rsp_res_den !== e.den || rsp_is_equal !== e.eq
                || rsp_den_zero !== e.dz || rsp_overflow !== e.ovf) begin
               $display("%0t: expected %0d/%0d eq%b dz%b ov%b, got %0d/%0d eq%b dz%b ov%b",
                        $time, e.num, e.den, e.eq, e.dz, e.ovf, rsp_res_num,
                        rsp_res_den, rsp_is_equal, rsp_den_zero, rsp_overflow);
               err_cnt++;
            end
         end
      end
   end

   initial begin
      req_row_type rw;
      int hold;
      err_cnt = 0; calm = 0; hold_rsp = 0;
      reset = 1; req_valid = 0; req_opcode = OP_NORM;
      req_a_num = 0; req_a_den = 0; req_b_num = 0; req_b_den = 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      add_row(OP_NORM, 0, 0, 0, 0, 1, '{0, 1, 0, 0, 0});
      add_row(OP_NORM, 0, 5, 0, 0, 1, '{0, 1, 0, 0, 0});
      add_row(OP_NORM, 7, 0, 0, 0, 1, '{1, 0, 0, 1, 0});
      add_row(OP_NORM, -7, 0, 0, 0, 1, '{-1, 0, 0, 1, 0});
      add_row(OP_NORM, 6, -4, 0, 0, 1, '{-3, 2, 0, 0, 0});
      add_row(OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, '{1, 1, 0, 0, 0});
      add_row(OP_NORM, 32'h8000_0000, 1, 0, 0, 1, '{-64'sd2147483648, 1, 0, 0, 0});
      add_row(OP_NORM, 32'h7FFF_FFFF, -1, 0, 0, 1, '{-64'sd2147483647, 1, 0, 0, 0});
      add_row(OP_ADD, 1, 2, 1, 3);
      add_row(OP_ADD, 1, 2, -1, 2, 1, '{0, 1, 0, 0, 0});
      add_row(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFD);
      add_row(OP_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
      add_row(OP_ADD, 3, 0, 1, 2);
      add_row(OP_ADD, 3, 0, -5, 0);
      add_row(OP_SUB, 1, 2, 1, 3);
      add_row(OP_SUB, 3, 4, 3, 4, 1, '{0, 1, 0, 0, 0});
      add_row(OP_SUB, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
      add_row(OP_SUB, 1, 0, 1, 0);
      add_row(OP_EQ, 2, 4, -1, -2, 1, '{0, 1, 1, 0, 0});
      add_row(OP_EQ, 2, 4, 1, -2, 1, '{0, 1, 0, 0, 0});
      add_row(OP_EQ, 0, 3, 0, -9, 1, '{0, 1, 1, 0, 0});
      add_row(OP_EQ, 5, 0, 9, 0, 1, '{0, 1, 1, 0, 0});
      add_row(OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              1, '{0, 1, 1, 0, 0});
      foreach (dir_tab[i]) send_req(dir_tab[i]);

      for (int i = 0; i < 650; i++) begin
         if (i == 100) begin
            hold_rsp = 1;
            fork
               begin
                  hold = 0;
                  while (hold < 3000) begin @(posedge clock); hold++; end
                  hold_rsp = 0;
               end
            join_none
         end
         if (i == 560) calm = 1;
         rw.op = $urandom_range(0, 3);
         rw.an = rand_operand(); rw.ad = rand_operand();
         rw.bn = rand_operand(); rw.bd = rand_operand();
         if (rw.op == OP_EQ && $urandom_range(0, 1)) begin
            rw.bn = rw.an * 3; rw.bd = rw.ad * 3;
         end
         rw.known = 0;
         send_req(rw);
      end
      req_valid <= 0;

      while (pending_fracs.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (err_cnt == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/rasn_pkg.sv
rtl/core/rasn_divu.sv
rtl/core/rational_add_sub_normalize.sv
bench/rational_add_sub_normalize_tb.sv
